// ===== rtl/core/elastic_disk_pair_collision_defines.svh =====
// ----------------------------------------------------------------------------
// elastic disk pair collision assertion macros
// shared property wrappers for the collision pipeline checks
// ----------------------------------------------------------------------------
`ifndef ELASTIC_DISK_PAIR_COLLISION_DEFINES_SVH
`define ELASTIC_DISK_PAIR_COLLISION_DEFINES_SVH

// same-cycle implication
`define EDPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/edpc_pkg.sv =====
// ----------------------------------------------------------------------------
// edpc_pkg
// shared constants and types of the disk pair collision pipeline
// ----------------------------------------------------------------------------
package edpc_pkg;

	localparam int unsigned MUL_CHUNK   = 32;
	localparam int unsigned RADIUS_W    = 30;
	localparam int unsigned MIN_DIST_W  = 16;
	localparam int unsigned MASS_W      = 16;
	localparam int unsigned SUM_W       = MASS_W + 1;
	localparam int unsigned TWO_R_W     = RADIUS_W + 1;
	localparam int unsigned TR2_W       = 2 * TWO_R_W;
	localparam int unsigned MD2_W       = 2 * MIN_DIST_W;
	localparam int unsigned CFG_DATA_W  = 30;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_DISK_RADIUS  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISTANCE = 1'd1;

	typedef struct packed {
		logic hit;
		logic flip_x;
		logic flip_y;
	} flags_t;

endpackage

// ===== rtl/core/edpc_mul.sv =====
// ----------------------------------------------------------------------------
// edpc_mul
// two-stage unsigned multiplier built from 32x32 partial products
// ----------------------------------------------------------------------------
module edpc_mul #(
	parameter int unsigned AW = 32,
	parameter int unsigned BW = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	localparam int unsigned CH = edpc_pkg::MUL_CHUNK;
	localparam int unsigned NA = (AW + CH - 1) / CH;
	localparam int unsigned NB = (BW + CH - 1) / CH;
	localparam int unsigned AP = NA * CH;
	localparam int unsigned BP = NB * CH;
	localparam int unsigned SW = (NA + NB) * CH;

	logic [AP-1:0]     a_pad;
	logic [BP-1:0]     b_pad;
	logic [2*CH-1:0]   pp_s1 [NA*NB];
	logic [SW-1:0]     acc;
	logic [AW+BW-1:0]  p_s2;

	assign a_pad = AP'(a);
	assign b_pad = BP'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i*NB+j] <= a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (SW'(pp_s1[i*NB+j]) << (CH * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[AW+BW-1:0];
		end
	end

	assign p = p_s2;

endmodule

// ===== rtl/core/edpc_dly.sv =====
// ----------------------------------------------------------------------------
// edpc_dly
// stallable delay line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module edpc_dly #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sr_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[DEPTH-1];

endmodule

// ===== rtl/core/edpc_div.sv =====
// ----------------------------------------------------------------------------
// edpc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module edpc_div #(
	parameter int unsigned NW  = 114,
	parameter int unsigned DDW = 82,
	parameter int unsigned QW  = 33
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NW-1:0]  n,
	input  logic [DDW-1:0] d,
	output logic [QW-1:0]  q
);

	localparam int unsigned CW = DDW + QW;

	logic [CW-1:0]  rem_p [QW+1];
	logic [DDW-1:0] den_p [QW+1];
	logic [QW-1:0]  quo_p [QW+1];

	assign rem_p[0] = CW'(n);
	assign den_p[0] = d;
	assign quo_p[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [CW:0] trial;

		// top bit goes first; a quotient of 2^QW or more comes out as all ones,
		// which still drives the velocity update into saturation
		assign trial = {1'b0, rem_p[i]} - ({1'b0, CW'(den_p[i])} << (QW - 1 - i));

		always_ff @(posedge clk) begin
			if (en) begin
				den_p[i+1] <= den_p[i];
				if (!trial[CW]) begin
					rem_p[i+1] <= trial[CW-1:0];
					quo_p[i+1] <= quo_p[i] | (QW'(1) << (QW - 1 - i));
				end else begin
					rem_p[i+1] <= rem_p[i];
					quo_p[i+1] <= quo_p[i];
				end
			end
		end
	end

	assign q = quo_p[QW];

endmodule

// ===== rtl/core/edpc_geom.sv =====
// ----------------------------------------------------------------------------
// edpc_geom
// separation, contact test and dot product of one disk pair (six stages)
// ----------------------------------------------------------------------------
module edpc_geom #(
	parameter int unsigned W = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [W-1:0]                  pos_a_x,
	input  logic [W-1:0]                  pos_a_y,
	input  logic [W-1:0]                  vel_a_x,
	input  logic [W-1:0]                  vel_a_y,
	input  logic [edpc_pkg::MASS_W-1:0]   mass_a,
	input  logic [W-1:0]                  pos_b_x,
	input  logic [W-1:0]                  pos_b_y,
	input  logic [W-1:0]                  vel_b_x,
	input  logic [W-1:0]                  vel_b_y,
	input  logic [edpc_pkg::MASS_W-1:0]   mass_b,
	input  logic [edpc_pkg::TWO_R_W-1:0]  two_r,
	input  logic [edpc_pkg::TR2_W-1:0]    tr2,
	input  logic [edpc_pkg::MD2_W-1:0]    md2,
	output logic [2*W:0]                  dot,
	output logic [2*W:0]                  d2,
	output logic [W-1:0]                  drm_x,
	output logic [W-1:0]                  drm_y,
	output logic [edpc_pkg::SUM_W-1:0]    msum,
	output logic [edpc_pkg::SUM_W-1:0]    ma2,
	output logic [edpc_pkg::SUM_W-1:0]    mb2,
	output edpc_pkg::flags_t              flags
);

	localparam int unsigned MW     = edpc_pkg::MASS_W;
	localparam int unsigned SW     = edpc_pkg::SUM_W;
	localparam int unsigned TRW    = edpc_pkg::TWO_R_W;
	localparam int unsigned TR2W   = edpc_pkg::TR2_W;
	localparam int unsigned RW     = (W > TRW) ? W : TRW;
	localparam int unsigned CW2    = (2 * W + 1 > TR2W) ? 2 * W + 1 : TR2W;
	localparam int unsigned SIDE_W = 5 + 2 * W + SW + 2 * MW;

	function automatic logic [W-1:0] mag(input logic [W:0] v);
		logic [W:0] t;
		t = v[W] ? (~v + 1'b1) : v;
		return t[W-1:0];
	endfunction

	// stage 1: differences
	logic [W:0]    dr_x_s1, dr_y_s1, dv_x_s1, dv_y_s1;
	logic [SW-1:0] msum_s1;
	logic [MW-1:0] ma_s1, mb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dr_x_s1 <= {pos_b_x[W-1], pos_b_x} - {pos_a_x[W-1], pos_a_x};
			dr_y_s1 <= {pos_b_y[W-1], pos_b_y} - {pos_a_y[W-1], pos_a_y};
			dv_x_s1 <= {vel_b_x[W-1], vel_b_x} - {vel_a_x[W-1], vel_a_x};
			dv_y_s1 <= {vel_b_y[W-1], vel_b_y} - {vel_a_y[W-1], vel_a_y};
			msum_s1 <= {1'b0, mass_a} + {1'b0, mass_b};
			ma_s1   <= mass_a;
			mb_s1   <= mass_b;
		end
	end

	// stage 2: magnitudes and box test
	logic [W-1:0]  drm_x_c, drm_y_c;
	logic [W-1:0]  drm_x_s2, drm_y_s2, dvm_x_s2, dvm_y_s2;
	logic          neg_x_s2, neg_y_s2, drneg_x_s2, drneg_y_s2, in_range_s2;
	logic [SW-1:0] msum_s2;
	logic [MW-1:0] ma_s2, mb_s2;

	assign drm_x_c = mag(dr_x_s1);
	assign drm_y_c = mag(dr_y_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			drm_x_s2    <= drm_x_c;
			drm_y_s2    <= drm_y_c;
			dvm_x_s2    <= mag(dv_x_s1);
			dvm_y_s2    <= mag(dv_y_s1);
			neg_x_s2    <= dr_x_s1[W] ^ dv_x_s1[W];
			neg_y_s2    <= dr_y_s1[W] ^ dv_y_s1[W];
			drneg_x_s2  <= dr_x_s1[W];
			drneg_y_s2  <= dr_y_s1[W];
			in_range_s2 <= (RW'(drm_x_c) <= RW'(two_r)) && (RW'(drm_y_c) <= RW'(two_r))
				&& (msum_s1 != '0);
			msum_s2     <= msum_s1;
			ma_s2       <= ma_s1;
			mb_s2       <= mb_s1;
		end
	end

	// stages 3 and 4: squares and per-axis products
	logic [2*W-1:0] sq_x_s4, sq_y_s4, p_x_s4, p_y_s4;

	edpc_mul #(.AW(W), .BW(W)) u_sq_x (
		.clk(clk), .en(en), .a(drm_x_s2), .b(drm_x_s2), .p(sq_x_s4)
	);
	edpc_mul #(.AW(W), .BW(W)) u_sq_y (
		.clk(clk), .en(en), .a(drm_y_s2), .b(drm_y_s2), .p(sq_y_s4)
	);
	edpc_mul #(.AW(W), .BW(W)) u_p_x (
		.clk(clk), .en(en), .a(dvm_x_s2), .b(drm_x_s2), .p(p_x_s4)
	);
	edpc_mul #(.AW(W), .BW(W)) u_p_y (
		.clk(clk), .en(en), .a(dvm_y_s2), .b(drm_y_s2), .p(p_y_s4)
	);

	logic [SIDE_W-1:0] side_s2, side_s4;
	logic              neg_x_s4, neg_y_s4, drneg_x_s4, drneg_y_s4, in_range_s4;
	logic [W-1:0]      drm_x_s4, drm_y_s4;
	logic [SW-1:0]     msum_s4;
	logic [MW-1:0]     ma_s4, mb_s4;

	assign side_s2 = {neg_x_s2, neg_y_s2, drneg_x_s2, drneg_y_s2, in_range_s2,
		drm_x_s2, drm_y_s2, msum_s2, ma_s2, mb_s2};

	edpc_dly #(.WIDTH(SIDE_W), .DEPTH(2)) u_side (
		.clk(clk), .en(en), .d(side_s2), .q(side_s4)
	);

	assign {neg_x_s4, neg_y_s4, drneg_x_s4, drneg_y_s4, in_range_s4,
		drm_x_s4, drm_y_s4, msum_s4, ma_s4, mb_s4} = side_s4;

	// stage 5: squared distance and signed dot product
	logic [2*W:0]  psum_c, pdxy_c, pdyx_c;
	logic          pge_c;
	logic [2*W:0]  d2_s5, dot_s5;
	logic          dot_neg_s5, drneg_x_s5, drneg_y_s5, in_range_s5;
	logic [W-1:0]  drm_x_s5, drm_y_s5;
	logic [SW-1:0] msum_s5;
	logic [MW-1:0] ma_s5, mb_s5;

	assign psum_c = {1'b0, p_x_s4} + {1'b0, p_y_s4};
	assign pdxy_c = {1'b0, p_x_s4} - {1'b0, p_y_s4};
	assign pdyx_c = {1'b0, p_y_s4} - {1'b0, p_x_s4};
	assign pge_c  = p_x_s4 >= p_y_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s5 <= {1'b0, sq_x_s4} + {1'b0, sq_y_s4};
			if (neg_x_s4 == neg_y_s4) begin
				dot_s5     <= psum_c;
				dot_neg_s5 <= neg_x_s4;
			end else if (pge_c) begin
				dot_s5     <= pdxy_c;
				dot_neg_s5 <= neg_x_s4;
			end else begin
				dot_s5     <= pdyx_c;
				dot_neg_s5 <= neg_y_s4;
			end
			drneg_x_s5  <= drneg_x_s4;
			drneg_y_s5  <= drneg_y_s4;
			in_range_s5 <= in_range_s4;
			drm_x_s5    <= drm_x_s4;
			drm_y_s5    <= drm_y_s4;
			msum_s5     <= msum_s4;
			ma_s5       <= ma_s4;
			mb_s5       <= mb_s4;
		end
	end

	// stage 6: distance window test, flip flags and doubled masses
	logic [2*W:0]     d2_s6, dot_s6;
	logic [W-1:0]     drm_x_s6, drm_y_s6;
	logic [SW-1:0]    msum_s6, ma2_s6, mb2_s6;
	edpc_pkg::flags_t flags_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s6.hit    <= in_range_s5 && (d2_s5 != '0)
				&& (CW2'(d2_s5) >= CW2'(md2)) && (CW2'(d2_s5) <= CW2'(tr2));
			flags_s6.flip_x <= dot_neg_s5 ^ drneg_x_s5;
			flags_s6.flip_y <= dot_neg_s5 ^ drneg_y_s5;
			d2_s6           <= d2_s5;
			dot_s6          <= dot_s5;
			drm_x_s6        <= drm_x_s5;
			drm_y_s6        <= drm_y_s5;
			msum_s6         <= msum_s5;
			ma2_s6          <= {ma_s5, 1'b0};
			mb2_s6          <= {mb_s5, 1'b0};
		end
	end

	assign dot   = dot_s6;
	assign d2    = d2_s6;
	assign drm_x = drm_x_s6;
	assign drm_y = drm_y_s6;
	assign msum  = msum_s6;
	assign ma2   = ma2_s6;
	assign mb2   = mb2_s6;
	assign flags = flags_s6;

endmodule

// ===== rtl/core/elastic_disk_pair_collision.sv =====
// ----------------------------------------------------------------------------
// elastic_disk_pair_collision
// throughput: one item per cycle while the output is not stalled
// the quotient pipeline resolves one bit a stage
// a stall on the output freezes every stage at once, nothing is dropped
// reset clears all valid bits, radius to 1.0 and min distance to 1 raw unit
// ----------------------------------------------------------------------------
`include "elastic_disk_pair_collision_defines.svh"

module elastic_disk_pair_collision #(
	parameter int unsigned WORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16,
	localparam int unsigned IN_W  = ((8 * WORD_WIDTH + 2 * edpc_pkg::MASS_W + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((4 * WORD_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pos_a_x, pos_a_y, vel_a_x, vel_a_y, mass_a, pos_b_x, pos_b_y, vel_b_x, vel_b_y, mass_b
	input  logic [IN_W-1:0]                   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
	output logic [OUT_W-1:0]                  m_tdata,
	// collided
	output logic                              m_tuser,
	input  logic                              cfg_wr_en,
	input  logic [edpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [edpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned W      = WORD_WIDTH;
	localparam int unsigned MW     = edpc_pkg::MASS_W;
	localparam int unsigned SW     = edpc_pkg::SUM_W;
	localparam int unsigned RAD_W  = edpc_pkg::RADIUS_W;
	localparam int unsigned MD_W   = edpc_pkg::MIN_DIST_W;
	localparam int unsigned TRW    = edpc_pkg::TWO_R_W;
	localparam int unsigned TR2W   = edpc_pkg::TR2_W;
	localparam int unsigned MD2W   = edpc_pkg::MD2_W;
	localparam int unsigned QW     = W + 1;
	localparam int unsigned D2W    = 2 * W + 1;
	localparam int unsigned DOTW   = 2 * W + 1;
	localparam int unsigned TW     = DOTW + W;
	localparam int unsigned NW     = TW + SW;
	localparam int unsigned DENW   = D2W + SW;
	localparam int unsigned LAT    = 10 + QW;
	localparam int unsigned FLAG_W = $bits(edpc_pkg::flags_t);

	// configuration
	logic [RAD_W-1:0]    radius_q;
	logic [MD_W-1:0]     min_dist_q;
	logic [2*RAD_W-1:0]  rsq;
	logic [TRW-1:0]      two_r_q;
	logic [TR2W-1:0]     tr2_q;
	logic [MD2W-1:0]     md2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= RAD_W'(1) << FRAC_BITS;
			min_dist_q <= MD_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				edpc_pkg::REG_DISK_RADIUS: begin
					radius_q <= cfg_data[RAD_W-1:0];
				end
				edpc_pkg::REG_MIN_DISTANCE: begin
					min_dist_q <= cfg_data[MD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign rsq = radius_q * radius_q;

	// thresholds are registered from the configuration registers in the cycle after a write
	always_ff @(posedge clk) begin
		two_r_q <= {radius_q, 1'b0};
		tr2_q   <= {rsq, 2'b00};
		md2_q   <= min_dist_q * min_dist_q;
	end

	// handshake and valid chain
	logic           en;
	logic [LAT-1:0] v_q;
	logic           m_tvalid_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_q        <= {v_q[LAT-2:0], s_tvalid};
			m_tvalid_q <= v_q[LAT-1];
		end
	end

	// input fields
	logic [W-1:0]  pos_a_x, pos_a_y, vel_a_x, vel_a_y;
	logic [W-1:0]  pos_b_x, pos_b_y, vel_b_x, vel_b_y;
	logic [MW-1:0] mass_a, mass_b;

	assign pos_a_x = s_tdata[0 +: W];
	assign pos_a_y = s_tdata[W +: W];
	assign vel_a_x = s_tdata[2*W +: W];
	assign vel_a_y = s_tdata[3*W +: W];
	assign mass_a  = s_tdata[4*W +: MW];
	assign pos_b_x = s_tdata[4*W+MW +: W];
	assign pos_b_y = s_tdata[5*W+MW +: W];
	assign vel_b_x = s_tdata[6*W+MW +: W];
	assign vel_b_y = s_tdata[7*W+MW +: W];
	assign mass_b  = s_tdata[8*W+MW +: MW];

	// geometry front end
	logic [DOTW-1:0]  dot_g;
	logic [D2W-1:0]   d2_g;
	logic [W-1:0]     drm_x_g, drm_y_g;
	logic [SW-1:0]    msum_g, ma2_g, mb2_g;
	edpc_pkg::flags_t flags_g;

	edpc_geom #(.W(W)) u_geom (
		.clk(clk), .en(en),
		.pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .vel_a_x(vel_a_x), .vel_a_y(vel_a_y),
		.mass_a(mass_a),
		.pos_b_x(pos_b_x), .pos_b_y(pos_b_y), .vel_b_x(vel_b_x), .vel_b_y(vel_b_y),
		.mass_b(mass_b),
		.two_r(two_r_q), .tr2(tr2_q), .md2(md2_q),
		.dot(dot_g), .d2(d2_g), .drm_x(drm_x_g), .drm_y(drm_y_g),
		.msum(msum_g), .ma2(ma2_g), .mb2(mb2_g), .flags(flags_g)
	);

	// denominator and numerators
	logic [DENW-1:0] den_m, den_d;
	logic [TW-1:0]   t_x, t_y;
	logic [SW-1:0]   ma2_d, mb2_d;
	logic [NW-1:0]   n_ax, n_bx, n_ay, n_by;

	edpc_mul #(.AW(D2W), .BW(SW)) u_den (
		.clk(clk), .en(en), .a(d2_g), .b(msum_g), .p(den_m)
	);
	edpc_mul #(.AW(DOTW), .BW(W)) u_t_x (
		.clk(clk), .en(en), .a(dot_g), .b(drm_x_g), .p(t_x)
	);
	edpc_mul #(.AW(DOTW), .BW(W)) u_t_y (
		.clk(clk), .en(en), .a(dot_g), .b(drm_y_g), .p(t_y)
	);
	edpc_dly #(.WIDTH(2 * SW), .DEPTH(2)) u_mass_dly (
		.clk(clk), .en(en), .d({ma2_g, mb2_g}), .q({ma2_d, mb2_d})
	);
	edpc_dly #(.WIDTH(DENW), .DEPTH(2)) u_den_dly (
		.clk(clk), .en(en), .d(den_m), .q(den_d)
	);

	// the partner's mass weights each disk's impulse
	edpc_mul #(.AW(TW), .BW(SW)) u_n_ax (
		.clk(clk), .en(en), .a(t_x), .b(mb2_d), .p(n_ax)
	);
	edpc_mul #(.AW(TW), .BW(SW)) u_n_bx (
		.clk(clk), .en(en), .a(t_x), .b(ma2_d), .p(n_bx)
	);
	edpc_mul #(.AW(TW), .BW(SW)) u_n_ay (
		.clk(clk), .en(en), .a(t_y), .b(mb2_d), .p(n_ay)
	);
	edpc_mul #(.AW(TW), .BW(SW)) u_n_by (
		.clk(clk), .en(en), .a(t_y), .b(ma2_d), .p(n_by)
	);

	// impulse quotients
	logic [QW-1:0] q_ax, q_bx, q_ay, q_by;

	edpc_div #(.NW(NW), .DDW(DENW), .QW(QW)) u_div_ax (
		.clk(clk), .en(en), .n(n_ax), .d(den_d), .q(q_ax)
	);
	edpc_div #(.NW(NW), .DDW(DENW), .QW(QW)) u_div_bx (
		.clk(clk), .en(en), .n(n_bx), .d(den_d), .q(q_bx)
	);
	edpc_div #(.NW(NW), .DDW(DENW), .QW(QW)) u_div_ay (
		.clk(clk), .en(en), .n(n_ay), .d(den_d), .q(q_ay)
	);
	edpc_div #(.NW(NW), .DDW(DENW), .QW(QW)) u_div_by (
		.clk(clk), .en(en), .n(n_by), .d(den_d), .q(q_by)
	);

	// side data aligned with the quotients
	logic [4*W-1:0]   vel_d;
	logic [W-1:0]     va_x_d, va_y_d, vb_x_d, vb_y_d;
	edpc_pkg::flags_t flags_d;

	edpc_dly #(.WIDTH(4 * W), .DEPTH(LAT)) u_vel_dly (
		.clk(clk), .en(en), .d({vel_b_y, vel_b_x, vel_a_y, vel_a_x}), .q(vel_d)
	);
	edpc_dly #(.WIDTH(FLAG_W), .DEPTH(LAT - 6)) u_flag_dly (
		.clk(clk), .en(en), .d(flags_g), .q(flags_d)
	);

	assign {vb_y_d, vb_x_d, va_y_d, va_x_d} = vel_d;

	// the quotient can reach nearly 2^(W+1), so the sum needs three guard bits
	function automatic logic [W-1:0] add_sat(
		input logic [W-1:0]  v,
		input logic [QW-1:0] q,
		input logic          sub
	);
		logic [W+2:0] ve;
		logic [W+2:0] qe;
		logic [W+2:0] s;
		ve = {{3{v[W-1]}}, v};
		qe = {2'b00, q};
		s  = sub ? (ve - qe) : (ve + qe);
		if (s[W+2:W-1] == 4'b0000 || s[W+2:W-1] == 4'b1111) begin
			return s[W-1:0];
		end else if (s[W+2]) begin
			return {1'b1, {(W-1){1'b0}}};
		end else begin
			return {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	// apply impulses and register the result
	logic [W-1:0]   va_x_n, va_y_n, vb_x_n, vb_y_n;
	logic [4*W-1:0] tdata_q;
	logic           collided_q;

	always_comb begin
		va_x_n = va_x_d;
		va_y_n = va_y_d;
		vb_x_n = vb_x_d;
		vb_y_n = vb_y_d;
		if (flags_d.hit) begin
			va_x_n = add_sat(va_x_d, q_ax, flags_d.flip_x);
			va_y_n = add_sat(va_y_d, q_ay, flags_d.flip_y);
			vb_x_n = add_sat(vb_x_d, q_bx, !flags_d.flip_x);
			vb_y_n = add_sat(vb_y_d, q_by, !flags_d.flip_y);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q    <= {vb_y_n, vb_x_n, va_y_n, va_x_n};
			collided_q <= flags_d.hit;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(tdata_q);
	assign m_tuser  = collided_q;

	`EDPC_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !en, $stable(v_q),
		"valid bits moved while the pipeline was stalled")
	`EDPC_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, v_q[0],
		"accepted item did not reach the first stage")
	`EDPC_ASSERT_NEXT(a_skip_passes, clk, arst_n, en && v_q[LAT-1] && !flags_d.hit,
		!collided_q && (tdata_q == $past(vel_d)), "skipped pair changed its velocities")

endmodule
